// ===== src/assert_macros.svh =====
// assertion helpers used by the ranger control stage rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define UER_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define UER_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define UER_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define UER_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== src/uer_pkg.sv =====
package uer_pkg;

	// tick counter width
	localparam int CNT_W = 24;

	// status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_NOECHO = 2'd1;
	localparam logic [1:0] ST_RANGE  = 2'd2;

	// configuration register set
	typedef struct packed {
		logic [15:0]      trigger_ticks;
		logic [CNT_W-1:0] echo_wait_limit;
		logic [CNT_W-1:0] echo_count_limit;
		logic [CNT_W-1:0] range_limit;
	} cfg_t;

	// control stage result handed to the distance stage
	typedef struct packed {
		logic             trigger;
		logic             done;
		logic [1:0]       status;
		logic [CNT_W-1:0] count;
	} ctrl_res_t;

endpackage

// ===== src/uer_cfg.sv =====
module uer_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [1:0]                   cfg_index,
	input  logic [uer_pkg::CNT_W-1:0]    cfg_data,
	output uer_pkg::cfg_t                cfg
);

	// register indexes
	localparam logic [1:0] REG_TRIGGER_TICKS    = 2'd0;
	localparam logic [1:0] REG_ECHO_WAIT_LIMIT  = 2'd1;
	localparam logic [1:0] REG_ECHO_COUNT_LIMIT = 2'd2;
	localparam logic [1:0] REG_RANGE_LIMIT      = 2'd3;

	// reset values
	localparam logic [15:0]               RST_TRIGGER_TICKS    = 16'd20;
	localparam logic [uer_pkg::CNT_W-1:0] RST_ECHO_WAIT_LIMIT  = 24'd5000000;
	localparam logic [uer_pkg::CNT_W-1:0] RST_ECHO_COUNT_LIMIT = 24'hffffff;
	localparam logic [uer_pkg::CNT_W-1:0] RST_RANGE_LIMIT      = 24'hffff00;

	uer_pkg::cfg_t cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.trigger_ticks    <= RST_TRIGGER_TICKS;
			cfg_q.echo_wait_limit  <= RST_ECHO_WAIT_LIMIT;
			cfg_q.echo_count_limit <= RST_ECHO_COUNT_LIMIT;
			cfg_q.range_limit      <= RST_RANGE_LIMIT;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TRIGGER_TICKS:    cfg_q.trigger_ticks    <= cfg_data[15:0];
				REG_ECHO_WAIT_LIMIT:  cfg_q.echo_wait_limit  <= cfg_data;
				REG_ECHO_COUNT_LIMIT: cfg_q.echo_count_limit <= cfg_data;
				REG_RANGE_LIMIT:      cfg_q.range_limit      <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== src/uer_ctrl.sv =====
`include "assert_macros.svh"

module uer_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic                 start_req,
	input  logic                 echo,
	input  uer_pkg::cfg_t        cfg,
	output uer_pkg::ctrl_res_t   res
);

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_TRIG,
		PH_WAIT,
		PH_COUNT
	} phase_t;

	localparam logic [uer_pkg::CNT_W-1:0] CNT_MAX = '1;
	localparam logic [uer_pkg::CNT_W-1:0] CNT_ONE = uer_pkg::CNT_W'(1);

	phase_t                      phase_q, phase_d;
	logic [uer_pkg::CNT_W-1:0]   tick_count_q, tick_count_d;
	logic [uer_pkg::CNT_W-1:0]   inc, sat_inc, fin_cnt;
	logic                        fin;

	assign inc     = tick_count_q + CNT_ONE;
	assign sat_inc = (tick_count_q == CNT_MAX) ? tick_count_q : inc;

	// next phase and this word's result
	always_comb begin
		phase_d      = phase_q;
		tick_count_d = tick_count_q;
		fin          = 1'b0;
		fin_cnt      = tick_count_q;
		res          = '0;
		case (phase_q)
			PH_IDLE: begin
				if (start_req) begin
					phase_d      = PH_TRIG;
					tick_count_d = '0;
				end
			end
			PH_TRIG: begin
				res.trigger  = 1'b1;
				tick_count_d = inc;
				if (inc >= {8'd0, cfg.trigger_ticks}) begin
					phase_d      = PH_WAIT;
					tick_count_d = '0;
				end
			end
			PH_WAIT: begin
				if (echo) begin
					phase_d      = PH_COUNT;
					tick_count_d = CNT_ONE;
					if (CNT_ONE >= cfg.echo_count_limit) begin
						fin     = 1'b1;
						fin_cnt = CNT_ONE;
					end
				end else begin
					tick_count_d = inc;
					if (inc >= cfg.echo_wait_limit || inc == '0) begin
						res.done     = 1'b1;
						res.status   = uer_pkg::ST_NOECHO;
						phase_d      = PH_IDLE;
						tick_count_d = '0;
					end
				end
			end
			PH_COUNT: begin
				if (echo) begin
					tick_count_d = sat_inc;
					if (sat_inc >= cfg.echo_count_limit) begin
						fin     = 1'b1;
						fin_cnt = sat_inc;
					end
				end else begin
					fin = 1'b1;
				end
			end
			default: begin
				phase_d      = PH_IDLE;
				tick_count_d = '0;
			end
		endcase

		// measurement finished: range check on the echo count
		if (fin) begin
			res.done     = 1'b1;
			res.count    = fin_cnt;
			res.status   = (fin_cnt < cfg.range_limit) ? uer_pkg::ST_OK : uer_pkg::ST_RANGE;
			phase_d      = PH_IDLE;
			tick_count_d = '0;
		end
	end

	// phase and tick counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			tick_count_q <= '0;
		end else if (step) begin
			phase_q      <= phase_d;
			tick_count_q <= tick_count_d;
		end
	end

	`UER_ASSERT_IMP(a_idle_cnt_zero, clk, arst_n, phase_q == PH_IDLE, tick_count_q == '0, "tick count not cleared in idle")
	`UER_ASSERT_IMP(a_trig_cnt_narrow, clk, arst_n, phase_q == PH_TRIG, tick_count_q[23:16] == 8'd0, "trigger count beyond 16 bits")
	`UER_ASSERT_IMP(a_noecho_from_wait, clk, arst_n, res.done && res.status == uer_pkg::ST_NOECHO, phase_q == PH_WAIT && !echo, "no-echo outside wait phase")
	`UER_ASSERT_NXT(a_echo_fall_ends, clk, arst_n, step && phase_q == PH_COUNT && !echo, phase_q == PH_IDLE, "echo fall did not end measurement")

endmodule

// ===== src/uer_dist.sv =====
module uer_dist (
	input  uer_pkg::ctrl_res_t   res,
	output logic [15:0]          distance
);

	// ceil(2^30 / 65): exact quotient for every 24-bit count
	localparam int                 SHIFT    = 30;
	localparam logic [23:0]        RECIP_65 = 24'd16519105;
	localparam logic [15:0]        DIST_MAX = 16'hffff;

	logic [47:0] prod;
	logic [17:0] quot;

	// divide by 65 through the reciprocal
	assign prod = {24'd0, res.count} * {24'd0, RECIP_65};
	assign quot = prod[47:SHIFT];

	// zero when no result is done; saturate, and report the full-scale code when not ok
	always_comb begin
		if (!res.done) begin
			distance = '0;
		end else if (res.status != uer_pkg::ST_OK) begin
			distance = DIST_MAX;
		end else if (quot[17:16] != 2'd0) begin
			distance = DIST_MAX;
		end else begin
			distance = quot[15:0];
		end
	end

endmodule

// ===== src/ultrasonic_echo_ranger.sv =====
// Ultrasonic echo ranger: trigger / echo timing for a pulse-echo range sensor.
// Input channel (in_valid/in_ready): one word per timer tick carrying
// start_req and the sampled echo level. Output channel (out_valid/out_ready):
// exactly one word per input word with the trigger level, done_res, status
// and distance (echo ticks / 65, saturating; 0xffff when not ok).
// Configuration port (cfg_we/cfg_index/cfg_data) writes one of the four
// limit registers, chosen by cfg_index; write only while no word is in flight.
// Each accepted word is registered in stage 1, then stage 2, then the output.
// Throughput: one word per cycle unless stalled. The phase state advances
// once per word in the control stage; the divide by 65 is a single
// reciprocal multiply in the following stage, registered into the output.
// Stall: when out_ready is low the three stages fill and then hold, in_ready
// drops once the pipeline is full; nothing is dropped or repeated.
// Reset: arst_n clears the pipeline valids, returns the phase to idle with a
// zero tick count and loads the register defaults.
module ultrasonic_echo_ranger (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         start_req,
	input  logic                         echo,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         trigger,
	output logic                         done_res,
	output logic [1:0]                   status,
	output logic [15:0]                  distance,
	input  logic                         cfg_we,
	input  logic [1:0]                   cfg_index,
	input  logic [uer_pkg::CNT_W-1:0]    cfg_data
);

	uer_pkg::cfg_t       cfg;
	uer_pkg::ctrl_res_t  ctrl_res, res_s2;

	logic        v_s1, v_s2, out_valid_q;
	logic        start_s1, echo_s1;
	logic        adv1, adv2, adv_out;
	logic        trigger_q, done_q;
	logic [1:0]  status_q;
	logic [15:0] distance_q, dist_calc;

	// stage advance: each stage moves when empty or its successor moves
	assign adv_out  = !out_valid_q || out_ready;
	assign adv2     = !v_s2 || adv_out;
	assign adv1     = !v_s1 || adv2;
	assign in_ready = adv1;

	uer_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	uer_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (v_s1 && adv2),
		.start_req (start_s1),
		.echo      (echo_s1),
		.cfg       (cfg),
		.res       (ctrl_res)
	);

	uer_dist u_dist (
		.res      (res_s2),
		.distance (dist_calc)
	);

	// pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv1) begin
				v_s1 <= in_valid;
			end
			if (adv2) begin
				v_s2 <= v_s1;
			end
			if (adv_out) begin
				out_valid_q <= v_s2;
			end
		end
	end

	// pipeline payload
	always_ff @(posedge clk) begin
		if (adv1 && in_valid) begin
			start_s1 <= start_req;
			echo_s1  <= echo;
		end
		if (adv2 && v_s1) begin
			res_s2 <= ctrl_res;
		end
		if (adv_out && v_s2) begin
			trigger_q  <= res_s2.trigger;
			done_q     <= res_s2.done;
			status_q   <= res_s2.status;
			distance_q <= dist_calc;
		end
	end

	assign out_valid = out_valid_q;
	assign trigger   = trigger_q;
	assign done_res  = done_q;
	assign status    = status_q;
	assign distance  = distance_q;

endmodule
